@@ design/pcc_pkg.sv @@
// Package for the particle code to charge block: charge table, sideband
// and class types, and the constants of the code scheme. No dependencies.
package pcc_pkg;

  localparam int CODE_W   = 32;
  localparam int CHARGE_W = 4;
  localparam int BIN_W    = 24;   // magnitudes below the ion limit fit here
  localparam int BCD_W    = 32;   // eight decimal digits
  localparam int IDX_W    = 7;
  localparam int ROM_N    = 100;

  localparam logic [CODE_W-1:0] ION_LIMIT   = 32'd10000000;
  localparam logic [CODE_W-1:0] SMALL_LIMIT = 32'd100;
  localparam logic [CODE_W-1:0] OVZ_0 = 32'd1000017;
  localparam logic [CODE_W-1:0] OVZ_1 = 32'd1000018;
  localparam logic [CODE_W-1:0] OVZ_2 = 32'd1000034;
  localparam logic [CODE_W-1:0] OVZ_3 = 32'd1000052;
  localparam logic [CODE_W-1:0] OVZ_4 = 32'd1000053;
  localparam logic [CODE_W-1:0] OVZ_5 = 32'd1000054;
  localparam logic [CODE_W-1:0] OV6_0 = 32'd5100061;
  localparam logic [CODE_W-1:0] OV6_1 = 32'd5100062;

  localparam logic signed [CHARGE_W-1:0] CHARGE_ROM [ROM_N] = '{
    -4'sd1, 4'sd2, -4'sd1, 4'sd2, -4'sd1, 4'sd2, -4'sd1, 4'sd2, 4'sd0, 4'sd0,
    -4'sd3, 4'sd0, -4'sd3, 4'sd0, -4'sd3, 4'sd0, -4'sd3, 4'sd0, 4'sd0, 4'sd0,
    4'sd0, 4'sd0, 4'sd0, 4'sd3, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0,
    4'sd3, 4'sd0, 4'sd3, 4'sd6, 4'sd0, 4'sd0, 4'sd3, 4'sd6, 4'sd0, 4'sd0,
    -4'sd1, 4'sd2, -4'sd1, 4'sd2, -4'sd1, 4'sd2, 4'sd0, 4'sd0, 4'sd0, 4'sd0,
    -4'sd3, 4'sd0, -4'sd3, 4'sd0, -4'sd3, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0,
    -4'sd1, 4'sd2, -4'sd1, 4'sd2, -4'sd1, 4'sd2, 4'sd0, 4'sd0, 4'sd0, 4'sd0,
    -4'sd3, 4'sd0, -4'sd3, 4'sd0, -4'sd3, 4'sd0, 4'sd3, 4'sd3, 4'sd0, 4'sd0,
    4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0,
    4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0
  };

  typedef struct packed {
    logic             neg;
    logic             kill;        // zero code or ion
    logic             rom_direct;  // magnitude 0..100
    logic             ov_zero;
    logic             ov_six;
    logic [IDX_W-1:0] mag7;
  } side_t;

  typedef enum logic [2:0] {
    CLS_ZERO       = 3'd0,
    CLS_ROM        = 3'd1,
    CLS_SIX        = 3'd2,
    CLS_MESON      = 3'd3,
    CLS_MESON_SWAP = 3'd4,
    CLS_DIQUARK    = 3'd5,
    CLS_BARYON     = 3'd6
  } cls_t;

  function automatic logic signed [CHARGE_W-1:0] quark_charge(logic [3:0] digit);
    if (digit == 4'd0 || digit > 4'd9) begin
      return '0;
    end
    return CHARGE_ROM[IDX_W'(digit - 4'd1)];
  endfunction

endpackage

@@ design/pcc_if.sv @@
// Stream interfaces for the particle code to charge block: input code
// channel and charge result channel. No dependencies.
interface pcc_code_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] particle_code;
  modport source (output valid, output particle_code, input ready);
  modport sink (input valid, input particle_code, output ready);
endinterface

interface pcc_charge_if;
  logic              valid;
  logic              ready;
  logic signed [3:0] charge_times_three;
  modport source (output valid, output charge_times_three, input ready);
  modport sink (input valid, input charge_times_three, output ready);
endinterface

@@ design/particle_code_to_charge_top.sv @@
// Top level of the particle code to charge block: abs and range check,
// three decimal conversion stages, classification and charge output.
// Depends on pcc_pkg, pcc_if and pcc_bcd_stage.
//
// Usage:
//   code   : sink channel, one signed 32-bit particle code per beat.
//   charge : source channel, one signed 4-bit charge times three per beat,
//            in the order the codes were taken.
// Throughput is one code per cycle while the receiver holds ready high:
// every stage is a register with a valid bit, and the decimal split runs
// as eight shift-add-3 steps in each of three stages.
// When the receiver holds ready low, the result stays on the output and the
// stages behind it keep filling; code.ready falls once all six are full.
// Reset empties every stage; no result is shown until a code is taken.
module particle_code_to_charge_top (
  input  logic          clk,
  input  logic          rst,
  pcc_code_if.sink      code,
  pcc_charge_if.source  charge
);
  import pcc_pkg::*;

  localparam int NSTG = 3;

  // stage 1: magnitude and flags
  logic              v1;
  logic              rdy1;
  side_t             side1;
  logic [BIN_W-1:0]  bin1;
  logic [CODE_W-1:0] mag;

  // decimal conversion chain
  logic              sv   [NSTG+1];
  logic              srdy [NSTG+1];
  side_t             sside[NSTG+1];
  logic [BCD_W-1:0]  sbcd [NSTG+1];
  logic [BIN_W-1:0]  sbin [NSTG+1];

  // stage 5: class
  logic                     v5;
  logic                     rdy5;
  cls_t                     cls5;
  logic                     neg5;
  logic [IDX_W-1:0]         idx5;
  logic signed [CHARGE_W-1:0] qc1, qc2, qc3;

  // output
  logic                     vo;
  logic                     rdyo;
  logic [CHARGE_W-1:0]      res;

  assign mag = code.particle_code[CODE_W-1] ? CODE_W'(-code.particle_code)
                                            : CODE_W'(code.particle_code);

  assign rdy1       = !v1 || srdy[0];
  assign code.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= code.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (code.valid && rdy1) begin
      side1.neg        <= code.particle_code[CODE_W-1];
      side1.kill       <= (mag == '0) || (mag >= ION_LIMIT);
      side1.rom_direct <= (mag <= SMALL_LIMIT);
      side1.ov_zero    <= (mag == OVZ_0) || (mag == OVZ_1) || (mag == OVZ_2) ||
                          (mag == OVZ_3) || (mag == OVZ_4) || (mag == OVZ_5);
      side1.ov_six     <= (mag == OV6_0) || (mag == OV6_1);
      side1.mag7       <= mag[IDX_W-1:0];
      bin1             <= mag[BIN_W-1:0];
    end
  end

  assign sv[0]    = v1;
  assign sside[0] = side1;
  assign sbcd[0]  = '0;
  assign sbin[0]  = bin1;
  assign srdy[NSTG] = rdy5;

  for (genvar g = 0; g < NSTG; g++) begin : g_bcd
    pcc_bcd_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[g]),
      .in_ready  (srdy[g]),
      .side_in   (sside[g]),
      .bcd_in    (sbcd[g]),
      .bin_in    (sbin[g]),
      .out_valid (sv[g+1]),
      .out_ready (srdy[g+1]),
      .side_out  (sside[g+1]),
      .bcd_out   (sbcd[g+1]),
      .bin_out   (sbin[g+1])
    );
  end

  // stage 5: classify from decimal digits
  side_t      sd;
  logic [3:0] dj, d1, d2, d3, dx;
  cls_t       cls_next;
  logic [IDX_W-1:0] idx_next;

  assign sd = sside[NSTG];
  assign dj = sbcd[NSTG][3:0];
  assign d1 = sbcd[NSTG][7:4];
  assign d2 = sbcd[NSTG][11:8];
  assign d3 = sbcd[NSTG][15:12];
  assign dx = sbcd[NSTG][27:24];

  always_comb begin
    idx_next = sd.rom_direct ? sd.mag7
                             : IDX_W'({3'b000, d1} * 7'd10 + {3'b000, dj});
    if (sd.kill) begin
      cls_next = CLS_ZERO;
    end else if (sd.rom_direct) begin
      cls_next = CLS_ROM;
    end else if (dj == 4'd0) begin
      cls_next = CLS_ZERO;
    end else if (dx != 4'd0 && d3 == 4'd0 && d2 == 4'd0) begin
      if (sd.ov_six) begin
        cls_next = CLS_SIX;
      end else if (sd.ov_zero) begin
        cls_next = CLS_ZERO;
      end else begin
        cls_next = CLS_ROM;
      end
    end else if (d3 == 4'd0) begin
      cls_next = (d2 == 4'd3 || d2 == 4'd5) ? CLS_MESON_SWAP : CLS_MESON;
    end else if (d1 == 4'd0) begin
      cls_next = CLS_DIQUARK;
    end else begin
      cls_next = CLS_BARYON;
    end
  end

  assign rdy5 = !v5 || rdyo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= sv[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (sv[NSTG] && rdy5) begin
      cls5 <= cls_next;
      neg5 <= sd.neg;
      idx5 <= idx_next;
      qc1  <= quark_charge(d1);
      qc2  <= quark_charge(d2);
      qc3  <= quark_charge(d3);
    end
  end

  // output stage: table read, sum and sign
  logic signed [CHARGE_W-1:0] rom_v;
  logic signed [CHARGE_W:0]   q;
  logic signed [CHARGE_W:0]   q_signed;

  always_comb begin
    rom_v = '0;
    if (idx5 != '0 && idx5 <= IDX_W'(ROM_N)) begin
      rom_v = CHARGE_ROM[IDX_W'(idx5 - 1'b1)];
    end
    case (cls5)
      CLS_ZERO:       q = '0;
      CLS_ROM:        q = (CHARGE_W+1)'(rom_v);
      CLS_SIX:        q = 5'sd6;
      CLS_MESON:      q = (CHARGE_W+1)'(qc2) - (CHARGE_W+1)'(qc1);
      CLS_MESON_SWAP: q = (CHARGE_W+1)'(qc1) - (CHARGE_W+1)'(qc2);
      CLS_DIQUARK:    q = (CHARGE_W+1)'(qc3) + (CHARGE_W+1)'(qc2);
      CLS_BARYON:     q = (CHARGE_W+1)'(qc3) + (CHARGE_W+1)'(qc2) + (CHARGE_W+1)'(qc1);
      default:        q = '0;
    endcase
    q_signed = neg5 ? -q : q;
  end

  assign rdyo = !vo || charge.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (rdyo) begin
      vo <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (v5 && rdyo) begin
      res <= q_signed[CHARGE_W-1:0];
    end
  end

  assign charge.valid              = vo;
  assign charge.charge_times_three = res;

`ifndef NO_ASSERTIONS
  a_range: assert property (@(posedge clk) disable iff (rst)
    charge.valid |-> charge.charge_times_three >= -4'sd6 &&
                     charge.charge_times_three <= 4'sd6)
    else $error("charge out of range");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    v5 && rdyo && cls5 == CLS_ZERO |=> res == '0)
    else $error("zero class gave a nonzero charge");
  a_ion: assert property (@(posedge clk) disable iff (rst)
    code.valid && code.ready && code.particle_code == 32'sh80000000 |=> side1.kill)
    else $error("most negative code not treated as ion");
  a_cls_hold: assert property (@(posedge clk) disable iff (rst)
    v5 && !rdyo |=> v5 && $stable(cls5) && $stable(idx5))
    else $error("class stage changed while stalled");
`endif

endmodule

@@ design/pcc_bcd_stage.sv @@
// One pipeline stage of the binary to decimal conversion: eight
// shift-add-3 steps per beat. Depends on pcc_pkg.
module pcc_bcd_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pcc_pkg::side_t             side_in,
  input  logic [pcc_pkg::BCD_W-1:0]  bcd_in,
  input  logic [pcc_pkg::BIN_W-1:0]  bin_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pcc_pkg::side_t             side_out,
  output logic [pcc_pkg::BCD_W-1:0]  bcd_out,
  output logic [pcc_pkg::BIN_W-1:0]  bin_out
);
  import pcc_pkg::*;

  localparam int STEPS = 8;

  function automatic logic [BCD_W-1:0] dabble(logic [BCD_W-1:0] bcd,
                                              logic [STEPS-1:0] bits);
    logic [BCD_W-1:0] b;
    b = bcd;
    for (int i = 0; i < STEPS; i++) begin
      for (int k = 0; k < BCD_W / 4; k++) begin
        if (b[4*k +: 4] >= 4'd5) begin
          b[4*k +: 4] = b[4*k +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], bits[STEPS-1-i]};
    end
    return b;
  endfunction

  logic valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      side_out <= side_in;
      bcd_out  <= dabble(bcd_in, bin_in[BIN_W-1 -: STEPS]);
      bin_out  <= {bin_in[BIN_W-STEPS-1:0], {STEPS{1'b0}}};
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(bcd_out) && $stable(side_out))
    else $error("bcd stage lost or changed a stalled beat");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid)
    else $error("bcd stage dropped an accepted beat");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    valid && out_ready && !in_valid |=> !valid)
    else $error("bcd stage repeated a beat");
`endif

endmodule
